### rtl/core/fibonacci_range_sum_mod_top_defines.svh
// ----------------------------------------------------------------------------
// fibonacci_range_sum_mod_top_defines.svh
// Assertion macros shared by the Fibonacci range sum RTL.
// ----------------------------------------------------------------------------
`ifndef FIBONACCI_RANGE_SUM_MOD_TOP_DEFINES_SVH
`define FIBONACCI_RANGE_SUM_MOD_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every edge outside reset.
`define FRS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define FRS_ASSERT(lbl, clk, rst, prop)
`define FRS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/core/fibrs_pkg.sv
// ----------------------------------------------------------------------------
// fibrs_pkg
// Types, constants and modular helpers for the Fibonacci range sum block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fibrs_pkg;

   localparam int unsigned RES_W      = 30;
   localparam int unsigned IDX_W      = 62;
   localparam int unsigned KEY_W      = IDX_W + 1;
   localparam int unsigned STEP_CNT_W = $clog2(KEY_W);

   typedef logic [RES_W-1:0] res_type;

   localparam res_type FIB_MOD = 30'd1000000007;
   // floor(2^60 / p), Barrett reciprocal
   localparam logic [RES_W:0] BARRETT_MU = 31'((64'd1 << (2 * RES_W)) / 64'd1000000007);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_UPDATE,
      ST_FINAL
   } state_type;

   // product tags: lane 0 evaluates F(last+2), lane 1 F(first+1)
   typedef enum logic [2:0] {
      TAG_E_HI,
      TAG_F0SQ_HI,
      TAG_F1SQ_HI,
      TAG_E_LO,
      TAG_F0SQ_LO,
      TAG_F1SQ_LO
   } mm_tag_type;

   typedef struct packed {
      logic       valid;
      mm_tag_type tag;
   } mm_ctl_type;

   function automatic res_type add_mod(input res_type a, input res_type b);
      logic [RES_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, FIB_MOD}) begin
         s = s - {1'b0, FIB_MOD};
      end
      return s[RES_W-1:0];
   endfunction

   function automatic res_type sub_mod(input res_type a, input res_type b);
      logic [RES_W:0] d;
      if (a >= b) begin
         d = {1'b0, a} - {1'b0, b};
      end else begin
         d = {1'b0, a} + {1'b0, FIB_MOD} - {1'b0, b};
      end
      return d[RES_W-1:0];
   endfunction

endpackage

### rtl/core/fibrs_modmul.sv
// ----------------------------------------------------------------------------
// fibrs_modmul
// Five-stage pipelined modular multiplier, a*b mod p, Barrett reduction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fibonacci_range_sum_mod_top_defines.svh"

module fibrs_modmul (
   input  logic                  clock,
   input  logic                  reset,
   input  fibrs_pkg::mm_ctl_type op_ctl,
   input  fibrs_pkg::res_type    op_a,
   input  fibrs_pkg::res_type    op_b,
   output fibrs_pkg::mm_ctl_type res_ctl,
   output fibrs_pkg::res_type    res_data
);
   import fibrs_pkg::*;

   localparam int unsigned PROD_W = 2 * RES_W;
   localparam int unsigned Q_W    = RES_W + 1;
   localparam int unsigned Q2_W   = 2 * Q_W;
   localparam int unsigned LOW_W  = RES_W + 2;

   mm_ctl_type          ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff, ctl5_ff;
   mm_ctl_type          ctl1_in, ctl2_in, ctl3_in, ctl4_in, ctl5_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [Q2_W-1:0]     q2_ff, q2_in;
   logic [LOW_W-1:0]    x2_ff, x2_in, x3_ff, x3_in;
   logic [LOW_W-1:0]    t_ff, t_in;
   logic [LOW_W-1:0]    r_ff, r_in;
   res_type             out_ff, out_in;
   logic [PROD_W:0]     t_full;
   logic [LOW_W-1:0]    two_p;
   logic [LOW_W-1:0]    one_p;

   assign two_p = {1'b0, FIB_MOD, 1'b0};
   assign one_p = {2'b00, FIB_MOD};

   assign t_full = (PROD_W + 1)'(q2_ff[Q2_W-1:Q_W]) * (PROD_W + 1)'(FIB_MOD);

   always_comb begin
      ctl1_in = op_ctl;
      ctl2_in = ctl1_ff;
      ctl3_in = ctl2_ff;
      ctl4_in = ctl3_ff;
      ctl5_in = ctl4_ff;
      prod_in = PROD_W'(op_a) * PROD_W'(op_b);
      // q1 = x >> 29, q2 = q1 * mu
      q2_in   = Q2_W'(prod_ff[PROD_W-1:RES_W-1]) * Q2_W'(BARRETT_MU);
      x2_in   = prod_ff[LOW_W-1:0];
      x3_in   = x2_ff;
      t_in    = t_full[LOW_W-1:0];
      // remainder below 3p, fits the low word
      r_in    = x3_ff - t_ff;
      if (r_ff >= two_p) begin
         out_in = RES_W'(r_ff - two_p);
      end else if (r_ff >= one_p) begin
         out_in = RES_W'(r_ff - one_p);
      end else begin
         out_in = r_ff[RES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
         ctl5_ff <= '0;
      end else begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl2_in;
         ctl3_ff <= ctl3_in;
         ctl4_ff <= ctl4_in;
         ctl5_ff <= ctl5_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      q2_ff   <= q2_in;
      x2_ff   <= x2_in;
      x3_ff   <= x3_in;
      t_ff    <= t_in;
      r_ff    <= r_in;
      out_ff  <= out_in;
   end

   assign res_ctl  = ctl5_ff;
   assign res_data = out_ff;

   `FRS_ASSERT(a_mm_operands, clock, reset, !op_ctl.valid || (op_a < FIB_MOD && op_b < FIB_MOD))
   `FRS_ASSERT(a_mm_rem_bound, clock, reset, !ctl4_ff.valid || r_ff < (two_p + one_p))
   `FRS_ASSERT(a_mm_result, clock, reset, !res_ctl.valid || res_data < FIB_MOD)

endmodule

### rtl/core/fibonacci_range_sum_mod_top.sv
// ----------------------------------------------------------------------------
// fibonacci_range_sum_mod_top
// Sum of F(first..last) mod 1000000007 as F(last+2) - F(first+1).
// Evaluation: 63 bit steps from an accepted request to rsp_valid, each step
//   issuing six products through the 5-stage multiplier.
// One request at a time: req_stall is high while busy; new requests enter only in idle.
// Reset: synchronous, active high; clears sequencer and valid flags only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fibonacci_range_sum_mod_top_defines.svh"

module fibonacci_range_sum_mod_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fibrs_pkg::IDX_W-1:0]   req_first_index,
   input  logic [fibrs_pkg::IDX_W-1:0]   req_last_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fibrs_pkg::RES_W-1:0]   rsp_sum_mod
);
   import fibrs_pkg::*;

   // Two lanes run the fast-doubling walk side by side, MSB first:
   //   lane 0 -> F(last+2), lane 1 -> F(first+1).
   // Per bit step each lane needs F(2j) = f0*(2*f1 - f0) and
   // F(2j+1) = f0^2 + f1^2; the six products share one multiplier.

   state_type              state_ff, state_in;
   mm_tag_type             ph_ff, ph_in;          // issue phase = product tag
   logic [2:0]             ret_cnt_ff, ret_cnt_in;
   logic [STEP_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic                   empty_ff, empty_in;

   logic [KEY_W-1:0]       k_ff [2];
   logic [KEY_W-1:0]       k_in [2];
   res_type                f0_ff [2];
   res_type                f0_in [2];
   res_type                f1_ff [2];
   res_type                f1_in [2];
   res_type                e_ff [2];              // F(2j)
   res_type                e_in [2];
   res_type                sq_ff [2];             // f0^2, then F(2j+1)
   res_type                sq_in [2];

   mm_ctl_type             mm_ctl_ff, mm_ctl_in;
   res_type                mm_a_ff, mm_a_in;
   res_type                mm_b_ff, mm_b_in;
   mm_ctl_type             mm_res_ctl;
   res_type                mm_res_data;

   logic                   rsp_valid_ff, rsp_valid_in;
   res_type                rsp_sum_ff, rsp_sum_in;

   res_type                twice0, twice1;
   logic                   out_free;
   logic                   rets_done;

   fibrs_modmul u_modmul (
      .clock    (clock),
      .reset    (reset),
      .op_ctl   (mm_ctl_ff),
      .op_a     (mm_a_ff),
      .op_b     (mm_b_ff),
      .res_ctl  (mm_res_ctl),
      .res_data (mm_res_data)
   );

   // (2*f1 - f0) mod p for each lane; registered into the operand stage
   assign twice0    = sub_mod(add_mod(f1_ff[0], f1_ff[0]), f0_ff[0]);
   assign twice1    = sub_mod(add_mod(f1_ff[1], f1_ff[1]), f0_ff[1]);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rets_done = (ret_cnt_ff == 3'd6);

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (ph_ff == TAG_F1SQ_LO) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (rets_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (bit_cnt_ff == STEP_CNT_W'(KEY_W - 1)) begin
               state_in = ST_FINAL;
            end else begin
               state_in = ST_ISSUE;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- datapath and outputs ----------------
   always_comb begin
      ph_in        = ph_ff;
      ret_cnt_in   = ret_cnt_ff;
      bit_cnt_in   = bit_cnt_ff;
      empty_in     = empty_ff;
      k_in         = k_ff;
      f0_in        = f0_ff;
      f1_in        = f1_ff;
      e_in         = e_ff;
      sq_in        = sq_ff;
      mm_ctl_in    = '0;
      mm_a_in      = mm_a_ff;
      mm_b_in      = mm_b_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_sum_in   = rsp_sum_ff;

      // product writeback, in issue order
      if (mm_res_ctl.valid) begin
         ret_cnt_in = ret_cnt_ff + 3'd1;
         case (mm_res_ctl.tag)
            TAG_E_HI:    e_in[0]  = mm_res_data;
            TAG_F0SQ_HI: sq_in[0] = mm_res_data;
            TAG_F1SQ_HI: sq_in[0] = add_mod(sq_ff[0], mm_res_data);
            TAG_E_LO:    e_in[1]  = mm_res_data;
            TAG_F0SQ_LO: sq_in[1] = mm_res_data;
            TAG_F1SQ_LO: sq_in[1] = add_mod(sq_ff[1], mm_res_data);
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               k_in[0]    = {1'b0, req_last_index} + KEY_W'(2);
               k_in[1]    = {1'b0, req_first_index} + KEY_W'(1);
               f0_in[0]   = '0;
               f0_in[1]   = '0;
               f1_in[0]   = RES_W'(1);
               f1_in[1]   = RES_W'(1);
               empty_in   = (req_first_index > req_last_index);
               bit_cnt_in = '0;
               ph_in      = TAG_E_HI;
               ret_cnt_in = '0;
            end
         end
         ST_ISSUE: begin
            mm_ctl_in.valid = 1'b1;
            mm_ctl_in.tag   = ph_ff;
            case (ph_ff)
               TAG_E_HI: begin
                  mm_a_in = f0_ff[0];
                  mm_b_in = twice0;
               end
               TAG_F0SQ_HI: begin
                  mm_a_in = f0_ff[0];
                  mm_b_in = f0_ff[0];
               end
               TAG_F1SQ_HI: begin
                  mm_a_in = f1_ff[0];
                  mm_b_in = f1_ff[0];
               end
               TAG_E_LO: begin
                  mm_a_in = f0_ff[1];
                  mm_b_in = twice1;
               end
               TAG_F0SQ_LO: begin
                  mm_a_in = f0_ff[1];
                  mm_b_in = f0_ff[1];
               end
               TAG_F1SQ_LO: begin
                  mm_a_in = f1_ff[1];
                  mm_b_in = f1_ff[1];
               end
               default: begin
                  mm_ctl_in.valid = 1'b0;
               end
            endcase
            ph_in = mm_tag_type'(3'(ph_ff) + 3'd1);
         end
         ST_UPDATE: begin
            // index bit 1: (F(2j+1), F(2j+2)); bit 0: (F(2j), F(2j+1))
            for (int l = 0; l < 2; l++) begin
               if (k_ff[l][KEY_W-1]) begin
                  f0_in[l] = sq_ff[l];
                  f1_in[l] = add_mod(e_ff[l], sq_ff[l]);
               end else begin
                  f0_in[l] = e_ff[l];
                  f1_in[l] = sq_ff[l];
               end
               k_in[l] = {k_ff[l][KEY_W-2:0], 1'b0};
            end
            bit_cnt_in = bit_cnt_ff + STEP_CNT_W'(1);
            ret_cnt_in = '0;
            ph_in      = TAG_E_HI;
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = empty_ff ? '0 : sub_mod(f0_ff[0], f0_ff[1]);
            end
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ph_ff        <= TAG_E_HI;
         ret_cnt_ff   <= '0;
         bit_cnt_ff   <= '0;
         mm_ctl_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         ret_cnt_ff   <= ret_cnt_in;
         bit_cnt_ff   <= bit_cnt_in;
         mm_ctl_ff    <= mm_ctl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      empty_ff   <= empty_in;
      k_ff       <= k_in;
      f0_ff      <= f0_in;
      f1_ff      <= f1_in;
      e_ff       <= e_in;
      sq_ff      <= sq_in;
      mm_a_ff    <= mm_a_in;
      mm_b_ff    <= mm_b_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_sum_mod = rsp_sum_ff;

   // all six products of a step are back before the lanes advance
   `FRS_ASSERT(a_upd_all_back, clock, reset, state_ff != ST_UPDATE || rets_done)
   // the multiplier drains before the block reports idle
   `FRS_ASSERT(a_idle_drained, clock, reset, state_ff != ST_IDLE || !mm_res_ctl.valid)
   `FRS_ASSERT(a_lane0_range, clock, reset,
      state_ff == ST_IDLE || (f0_ff[0] < FIB_MOD && f1_ff[0] < FIB_MOD))
   `FRS_ASSERT(a_lane1_range, clock, reset,
      state_ff == ST_IDLE || (f0_ff[1] < FIB_MOD && f1_ff[1] < FIB_MOD))
   `FRS_ASSERT_NEXT(a_step_restart, clock, reset, state_ff == ST_UPDATE,
      ret_cnt_ff == 3'd0 && ph_ff == TAG_E_HI)

endmodule

### sim/tb_fibonacci_range_sum_mod_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fibonacci_range_sum_mod_top
// Self-checking bench for the Fibonacci range sum mod 1000000007 block.
// A local doubling-walk predictor computes F(last+2) - F(first+1) for every
// accepted request. Responses are checked in order against the queued sums.
// Sender bursts and gaps, receiver stall patterns and one long hold-off
// exercise the valid/stall handshake on both sides.
// ----------------------------------------------------------------------------

module tb_fibonacci_range_sum_mod_top;

   localparam int unsigned IDX_W       = fibrs_pkg::IDX_W;
   localparam int unsigned RES_W       = fibrs_pkg::RES_W;
   localparam logic [63:0] PRIME       = 64'd1000000007;
   localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};
   // hard cycle limit: all 1163 requests plus gaps and stalls,
   // taken several times over
   localparam int unsigned CYCLE_LIMIT = 12_000_000;
   localparam int unsigned HOLD_CYCLES = 4000;
   // drain time after the last response, a bit over one full evaluation
   localparam int unsigned TAIL_CYCLES = 1000;
   localparam int unsigned RANDOM_REQS = 1140;

   typedef logic [IDX_W-1:0] index_type;

   typedef struct {
      index_type          first;
      index_type          last;
      fibrs_pkg::res_type sum;
   } range_sum_type;

   // ------------------------------------------------------------------------
   // DUT signals, inputs known from time zero
   // ------------------------------------------------------------------------
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   index_type          req_first_index = '0;
   index_type          req_last_index = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [RES_W-1:0]   rsp_sum_mod;

   // expected sums, oldest first
   range_sum_type pending_sums[$];
   int unsigned  fail_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  burst_left = 0;

   // hold-off handshake: test flips hold_req, the stall process acks it
   logic         hold_req = 1'b0;
   logic         hold_seen = 1'b0;
   int unsigned  hold_left = 0;

   fibonacci_range_sum_mod_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_first_index (req_first_index),
      .req_last_index  (req_last_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sum_mod     (rsp_sum_mod)
   );

   // ------------------------------------------------------------------------
   // Clock, and a hard stop in case the pipeline hangs
   // ------------------------------------------------------------------------
   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   // F(k) mod p, doubling walk over all 64 bits of k, MSB first.
   // Operands stay below 2^30, so every product fits in 64 bits.
   function automatic logic [63:0] fib_mod(input logic [63:0] k);
      logic [63:0] f_lo;
      logic [63:0] f_hi;
      logic [63:0] twice;
      logic [63:0] even_term;
      logic [63:0] odd_term;
      int          bit_idx;
      f_lo = 64'd0;
      f_hi = 64'd1;
      for (bit_idx = 63; bit_idx >= 0; bit_idx--) begin
         twice     = ((f_hi << 1) + PRIME - f_lo) % PRIME;
         even_term = (f_lo * twice) % PRIME;
         odd_term  = ((f_lo * f_lo) % PRIME + (f_hi * f_hi) % PRIME) % PRIME;
         if (k[bit_idx]) begin
            f_lo = odd_term;
            f_hi = (even_term + odd_term) % PRIME;
         end else begin
            f_lo = even_term;
            f_hi = odd_term;
         end
      end
      return f_lo;
   endfunction

   // telescoped range sum; empty range gives zero
   function automatic fibrs_pkg::res_type range_sum_mod(input index_type first,
                                                        input index_type last);
      logic [63:0] upper;
      logic [63:0] lower;
      if (first > last) begin
         return '0;
      end
      upper = fib_mod({2'b00, last} + 64'd2);
      lower = fib_mod({2'b00, first} + 64'd1);
      return fibrs_pkg::res_type'((upper + PRIME - lower) % PRIME);
   endfunction

   // ------------------------------------------------------------------------
   // Receiver: own stall pattern plus an on-demand long hold-off
   // ------------------------------------------------------------------------
   // modes: 0 never stall, 1 light random, 2 heavy random, 3 square wave
   int unsigned stall_mode = 0;
   int unsigned mode_left = 0;
   int unsigned wave_phase = 0;

   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 3000);
         end else begin
            mode_left--;
         end
         wave_phase++;
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
               rsp_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_stall <= (wave_phase % 16) < 7;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Response checker: every accepted transaction pops the oldest sum
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      range_sum_type expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sums.size() == 0) begin
            $error("unexpected response transaction, sum_mod %0d", rsp_sum_mod);
            fail_count++;
         end else begin
            expected = pending_sums.pop_front();
            if (rsp_sum_mod !== expected.sum) begin
               $error("sum_mod mismatch for range %0d..%0d: expected %0d, actual %0d",
                      expected.first, expected.last, expected.sum, rsp_sum_mod);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------------
   // Offers one range and waits for acceptance. Valid stays up within a
   // burst; at a burst end it drops for a random, nonzero gap.
   task automatic send_range(input index_type first, input index_type last);
      range_sum_type entry;
      req_valid       <= 1'b1;
      req_first_index <= first;
      req_last_index  <= last;
      do begin
         @(posedge clock);
      end while (!(req_valid && !req_stall));
      entry.first = first;
      entry.last  = last;
      entry.sum   = range_sum_mod(first, last);
      pending_sums.push_back(entry);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         // mostly short gaps, now and then a long one that can outlast an evaluation
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 1000)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // sender goes quiet until every queued sum has come back
   task automatic wait_all_sums;
      req_valid <= 1'b0;
      while (pending_sums.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic index_type random_index();
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      return raw[IDX_W-1:0];
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // small ranges that are easy to check by hand, plus single-element ranges
   task automatic test_small_ranges;
      send_range(index_type'(0), index_type'(0));
      send_range(index_type'(0), index_type'(1));
      send_range(index_type'(1), index_type'(1));
      send_range(index_type'(2), index_type'(5));
      send_range(index_type'(5), index_type'(5));
      send_range(index_type'(10), index_type'(20));
      send_range(index_type'(0), index_type'(90));
   endtask

   // largest indices: last+2 uses the top bit of the walk
   task automatic test_extreme_indices;
      send_range(IDX_MAX, IDX_MAX);
      send_range(index_type'(0), IDX_MAX);
      send_range(IDX_MAX - 1, IDX_MAX);
      send_range(index_type'(1) << (IDX_W - 1), IDX_MAX);
      send_range({(IDX_W/2){2'b01}}, {(IDX_W/2){2'b10}});
      send_range(IDX_MAX - 1, IDX_MAX - 1);
   endtask

   // first > last must give zero without touching the walk result
   task automatic test_empty_ranges;
      send_range(index_type'(1), index_type'(0));
      send_range(IDX_MAX, index_type'(0));
      send_range(IDX_MAX, IDX_MAX - 1);
      send_range({(IDX_W/2){2'b10}}, {(IDX_W/2){2'b01}});
   endtask

   // receiver holds off while the sender keeps offering, so the block
   // keeps a result parked and stalls its input
   task automatic test_backpressure_fill;
      hold_req = ~hold_req;
      repeat (4) begin
         send_range(random_index(), IDX_MAX);
      end
   endtask

   // two requests, then a full drain before anything else goes in
   task automatic test_drain_pause;
      send_range(index_type'(3), index_type'(1000));
      send_range(random_index(), random_index());
      wait_all_sums();
      repeat ($urandom_range(1, 20)) @(posedge clock);
   endtask

   // random ranges: mostly ordered pairs, some small, equal and empty ones
   task automatic test_random_ranges;
      index_type   a;
      index_type   b;
      index_type   t;
      int unsigned kind;
      repeat (RANDOM_REQS) begin
         a    = random_index();
         b    = random_index();
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            if (a > b) begin
               t = a;
               a = b;
               b = t;
            end
         end else if (kind < 70) begin
            a = index_type'($urandom_range(0, 200));
            b = index_type'($urandom_range(0, 200));
         end else if (kind < 80) begin
            b = a;
         end else if (kind < 90) begin
            // empty range
            if (a < b) begin
               t = a;
               a = b;
               b = t;
            end else if (a == b) begin
               a = b + 1;
               if (a == 0) begin
                  b = IDX_MAX - 1;
                  a = IDX_MAX;
               end
            end
         end else if (kind < 95) begin
            a = ($urandom_range(0, 1) == 0) ? index_type'(0) : IDX_MAX - a[3:0];
            b = IDX_MAX - b[3:0];
         end
         send_range(a, b);
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_small_ranges();
      test_extreme_indices();
      test_empty_ranges();
      test_backpressure_fill();
      test_drain_pause();
      test_random_ranges();

      wait_all_sums();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_sums.size() != 0) begin
         $error("%0d expected sums never arrived", pending_sums.size());
         fail_count++;
      end

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
